// File: src/positional_list_range_xor_unit_assert.svh
// Assertion macros shared by the positional list range XOR unit.
`ifndef POSITIONAL_LIST_RANGE_XOR_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_RANGE_XOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define PLR_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define PLR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PLR_ASSERT(lbl, clk_s, rstn_s, prop)
`define PLR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// File: src/plr_pkg.sv
// Shared types and constants of the positional list range XOR unit.
package plr_pkg;

    // Fixed field widths of the stream items.
    localparam int CMD_W      = 2;
    localparam int POS_W      = 11;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (DATA_W + STATUS_W + COUNT_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2
    } cell_op_t;

    typedef enum logic {
        CTRL_IDLE  = 1'b0,
        CTRL_SWEEP = 1'b1
    } ctrl_state_t;

endpackage

// File: src/plr_cell.sv
// One storage cell of the row: holds one element and one stage of the XOR chain.
module plr_cell #(
    parameter int VW    = 32,
    parameter int PW    = 12,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  plr_pkg::cell_op_t op,
    input  logic [PW-1:0]     slot,
    input  logic [VW-1:0]     ins_value,
    input  logic [VW-1:0]     left_value,
    input  logic [VW-1:0]     right_value,
    input  logic [PW-1:0]     lo,
    input  logic [PW-1:0]     hi,
    input  logic [VW-1:0]     acc_in,
    output logic [VW-1:0]     value,
    output logic [VW-1:0]     acc_out
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);
    localparam logic [PW-1:0] POS = PW'(INDEX + 1);

    logic [VW-1:0] data_reg;
    logic [VW-1:0] data_next;
    logic [VW-1:0] acc_reg;
    logic [VW-1:0] acc_next;
    logic          in_range;

    // Insert opens a gap at the slot by taking the left neighbor's value;
    // erase closes the gap by taking the right neighbor's value.
    always_comb
    begin
        data_next = data_reg;
        case (op)
            plr_pkg::CELL_INSERT:
            begin
                if (IDX == slot)
                    data_next = ins_value;
                else if (IDX > slot)
                    data_next = left_value;
            end
            plr_pkg::CELL_ERASE:
            begin
                if (IDX >= slot)
                    data_next = right_value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    assign in_range = (POS >= lo) && (POS <= hi);
    assign acc_next = acc_in ^ (in_range ? data_reg : '0);

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        acc_reg  <= acc_next;
    end

    assign value   = data_reg;
    assign acc_out = acc_reg;

endmodule

// File: src/plr_cell_row.sv
// Row of storage cells with neighbor links and the running XOR chain.
module plr_cell_row #(
    parameter int CAPACITY = 1024,
    parameter int VW       = 32,
    parameter int PW       = 12
) (
    input  logic              clk,
    input  plr_pkg::cell_op_t op,
    input  logic [PW-1:0]     slot,
    input  logic [VW-1:0]     ins_value,
    input  logic [PW-1:0]     lo,
    input  logic [PW-1:0]     hi,
    output logic [VW-1:0]     acc_last
);

    logic [VW-1:0] cell_value [CAPACITY];
    logic [VW-1:0] cell_acc   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VW-1:0] left_v;
        logic [VW-1:0] right_v;
        logic [VW-1:0] acc_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
            assign acc_v  = '0;
        end
        else
        begin : g_inner
            assign left_v = cell_value[i-1];
            assign acc_v  = cell_acc[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_next
            assign right_v = cell_value[i+1];
        end

        plr_cell #(
            .VW    (VW),
            .PW    (PW),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .slot        (slot),
            .ins_value   (ins_value),
            .left_value  (left_v),
            .right_value (right_v),
            .lo          (lo),
            .hi          (hi),
            .acc_in      (acc_v),
            .value       (cell_value[i]),
            .acc_out     (cell_acc[i])
        );
    end

    assign acc_last = cell_acc[CAPACITY-1];

endmodule

// File: src/positional_list_range_xor_unit.sv
// Top level of the positional list range XOR unit: control, count and output register.
// Insert, erase and the unused command code give their result item in the cycle after accept,
// and a new item can be taken every cycle while results are drained.
// A query blocks input while the XOR chain sweeps: the sweep counter counts down from
// CAPACITY, the chain moves one cell along the row per cycle, and then the result is loaded.
// Reset (rst_n low, asynchronous) clears the element count and control state; the cell
// contents stay undefined until written and need no clearing pass.
`include "positional_list_range_xor_unit_assert.svh"

module positional_list_range_xor_unit #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items. tdata from bit 0: position[10:0], value[42:11], range_left[53:43],
    // range_right[64:54], zero fill above.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [plr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser from bit 0: command[1:0].
    input  logic [plr_pkg::CMD_W-1:0]        s_tuser,
    // Result items. tdata from bit 0: xor_result[31:0], status[33:32],
    // element_count[44:34], zero fill above.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [plr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int VW  = VALUE_WIDTH;
    localparam int DW  = plr_pkg::DATA_W;
    localparam int CW  = plr_pkg::COUNT_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Position width: wide enough for the input field, the count, and count plus one.
    localparam int PW  = ((plr_pkg::POS_W > CNT_W) ? plr_pkg::POS_W : CNT_W) + 1;
    localparam int SW  = $clog2(CAPACITY + 1);

    // Input field unpacking.
    logic [plr_pkg::POS_W-1:0] in_position;
    logic [DW-1:0]             in_value;
    logic [plr_pkg::POS_W-1:0] in_left;
    logic [plr_pkg::POS_W-1:0] in_right;
    plr_pkg::cmd_t             in_cmd;

    assign in_position = s_tdata[10:0];
    assign in_value    = s_tdata[42:11];
    assign in_left     = s_tdata[53:43];
    assign in_right    = s_tdata[64:54];
    assign in_cmd      = plr_pkg::cmd_t'(s_tuser);

    // Registers.
    plr_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SW-1:0]        sweep_reg, sweep_next;
    logic [PW-1:0]        lo_reg, lo_next;
    logic [PW-1:0]        hi_reg, hi_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VW-1:0]        out_xor_reg, out_xor_next;
    plr_pkg::status_t     out_status_reg, out_status_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    // Decode of the accepted item.
    logic              accept;
    logic              store_full;
    logic              erase_absent;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     ins_pos;
    logic [PW-1:0]     left_ext;
    logic [PW-1:0]     right_ext;
    logic              sweep_done;

    // Cell row control.
    plr_pkg::cell_op_t cell_op;
    logic [PW-1:0]     cell_slot;
    logic [VW-1:0]     acc_last;

    // The block takes an item only between queries, and only when the output
    // register is free or being emptied in the same cycle.
    assign s_tready = (state_reg == plr_pkg::CTRL_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign pos_ext    = PW'(in_position);
    assign cnt_ext    = PW'(count_reg);
    assign left_ext   = PW'(in_left);
    assign right_ext  = PW'(in_right);
    assign store_full = (count_reg == CNT_W'(CAPACITY));
    assign erase_absent = (pos_ext == '0) || (pos_ext > cnt_ext);
    assign sweep_done = (state_reg == plr_pkg::CTRL_SWEEP) && (sweep_reg == '0);

    // An insert at position zero goes to the front; past the end it appends.
    always_comb
    begin
        ins_pos = (pos_ext == '0) ? PW'(1) : pos_ext;
        if (ins_pos > cnt_ext + PW'(1))
            ins_pos = cnt_ext + PW'(1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plr_pkg::CTRL_IDLE:
            begin
                if (accept && (in_cmd == plr_pkg::CMD_QUERY))
                    state_next = plr_pkg::CTRL_SWEEP;
            end
            plr_pkg::CTRL_SWEEP:
            begin
                if (sweep_reg == '0)
                    state_next = plr_pkg::CTRL_IDLE;
            end
            default:
            begin
                state_next = plr_pkg::CTRL_IDLE;
            end
        endcase
    end

    // Datapath control and output register loading.
    always_comb
    begin
        cell_op         = plr_pkg::CELL_HOLD;
        cell_slot       = '0;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_xor_next    = out_xor_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        if (state_reg == plr_pkg::CTRL_SWEEP && sweep_reg != '0)
            sweep_next = sweep_reg - SW'(1);

        if (sweep_done)
        begin
            // The chain has carried the masked XOR through every cell.
            out_valid_next  = 1'b1;
            out_xor_next    = acc_last;
            out_status_next = plr_pkg::ST_DONE;
            out_count_next  = count_reg;
        end

        if (accept)
        begin
            out_xor_next    = '0;
            out_status_next = plr_pkg::ST_DONE;
            case (in_cmd)
                plr_pkg::CMD_INSERT:
                begin
                    if (store_full)
                    begin
                        out_status_next = plr_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_op    = plr_pkg::CELL_INSERT;
                        cell_slot  = ins_pos - PW'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                end
                plr_pkg::CMD_ERASE:
                begin
                    if (erase_absent)
                    begin
                        out_status_next = plr_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        cell_op    = plr_pkg::CELL_ERASE;
                        cell_slot  = pos_ext - PW'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                end
                plr_pkg::CMD_QUERY:
                begin
                    // Clamp the range; the result waits for the sweep.
                    lo_next    = (left_ext == '0) ? PW'(1) : left_ext;
                    hi_next    = (right_ext > cnt_ext) ? cnt_ext : right_ext;
                    sweep_next = SW'(CAPACITY);
                end
                default:
                begin
                    // The unused command code changes nothing.
                    out_valid_next = 1'b1;
                end
            endcase
            out_count_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plr_pkg::CTRL_IDLE;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        out_xor_reg    <= out_xor_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    plr_cell_row #(
        .CAPACITY (CAPACITY),
        .VW       (VW),
        .PW       (PW)
    ) u_row (
        .clk       (clk),
        .op        (cell_op),
        .slot      (cell_slot),
        .ins_value (VW'(in_value)),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .acc_last  (acc_last)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{plr_pkg::OUT_PAD_W{1'b0}}, CW'(out_count_reg), out_status_reg,
                       DW'(out_xor_reg)};

    // No item is taken while the XOR chain is still sweeping.
    `PLR_ASSERT(a_no_accept_in_sweep, clk, rst_n,
        !((state_reg == plr_pkg::CTRL_SWEEP) && s_tready))
    // The element count never passes the capacity.
    `PLR_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY))
    // A rejected insert into a full store leaves the count alone.
    `PLR_ASSERT_NEXT(a_full_insert_holds, clk, rst_n,
        accept && (in_cmd == plr_pkg::CMD_INSERT) && store_full,
        count_reg == $past(count_reg))
    // Every accepted item other than a query has its result ready in the next cycle.
    `PLR_ASSERT_NEXT(a_quick_result, clk, rst_n,
        accept && (in_cmd != plr_pkg::CMD_QUERY), m_tvalid)

endmodule
